// ----- sv/mcfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfd_pkg
// Shared types and constants of the multi-CPU first-come dispatcher.
// ----------------------------------------------------------------------------
package mcfd_pkg;

  // Default sizes
  localparam int MAX_PROCS_DEF = 16;
  localparam int NUM_CPUS_DEF  = 4;

  // Fixed field widths
  localparam int TIME_W  = 16;
  localparam int ID_W    = 8;
  localparam int WORK_W  = 12;
  localparam int PC_W    = 5;
  localparam int NC_W    = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [PC_W-1:0]   PC_RESET = 5'd16;
  localparam logic [NC_W-1:0]   NC_RESET = 3'd4;

  // Input operations
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CPUS_IN_USE   = 1'b1;

  // Result kinds
  localparam logic [1:0] EV_DISPATCH = 2'd0;
  localparam logic [1:0] EV_FINISH   = 2'd1;
  localparam logic [1:0] EV_TICK_END = 2'd2;

  typedef enum logic [1:0] {
    ST_NEW     = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_DONE    = 2'd3
  } proc_status_t;

  // One process table entry
  typedef struct packed {
    logic [ID_W-1:0]   ident;
    logic [TIME_W-1:0] arrival;
    logic [WORK_W-1:0] burst;
    logic [WORK_W-1:0] remaining;
    proc_status_t      status;
  } proc_entry_t;

  // Result register contents
  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        cpu;
    logic [3:0]        pslot;
    logic [ID_W-1:0]   pid;
    logic [TIME_W-1:0] etime;
    logic [TIME_W-1:0] resp;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wait_t;
    logic              all_done;
    logic              last;
  } event_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISP,
    S_EXEC,
    S_END
  } seq_state_t;

endpackage

// ----- sv/mcfd_proc_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfd_proc_mem
// Process table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mcfd_proc_mem #(
  parameter int DEPTH = mcfd_pkg::MAX_PROCS_DEF,
  parameter int AW    = 4
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  mcfd_pkg::proc_entry_t wr_data,
  input  logic [AW-1:0]         rd_addr,
  output mcfd_pkg::proc_entry_t rd_data
);
  import mcfd_pkg::*;

  proc_entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- sv/multi_cpu_fcfs_dispatcher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_cpu_fcfs_dispatcher
// Non-preemptive first-come dispatcher for several CPUs over a process table.
// ----------------------------------------------------------------------------
// Load: busy stays low, no results.
// Tick: busy through the slot scan, the CPU pass and the tick end; the scan
//   reads one slot per cycle and stops at the last slot in use or once no
//   CPU in use is idle. A new tick is taken only while busy is low.
// Results stream out at most one per cycle, the tick end in the cycle busy drops.
// Reset (rst, synchronous): CPUs idle, time zero, 16 processes and 4 CPUs in use;
//   the process table is not cleared.
module multi_cpu_fcfs_dispatcher #(
  parameter int MAX_PROCS = mcfd_pkg::MAX_PROCS_DEF,
  parameter int NUM_CPUS  = mcfd_pkg::NUM_CPUS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              op,
  input  logic [3:0]                        slot,
  input  logic [mcfd_pkg::ID_W-1:0]         process_id,
  input  logic [mcfd_pkg::TIME_W-1:0]       arrival,
  input  logic [mcfd_pkg::WORK_W-1:0]       burst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mcfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcfd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              result_valid,
  output logic [1:0]                        event_kind,
  output logic [1:0]                        cpu_index,
  output logic [3:0]                        process_slot,
  output logic [mcfd_pkg::ID_W-1:0]         pid_out,
  output logic [mcfd_pkg::TIME_W-1:0]       event_time,
  output logic [mcfd_pkg::TIME_W-1:0]       response_time,
  output logic [mcfd_pkg::TIME_W-1:0]       turnaround_time,
  output logic [mcfd_pkg::TIME_W-1:0]       waiting_time,
  output logic                              all_done,
  output logic                              last
);
  import mcfd_pkg::*;

  localparam int SLOT_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int CNT_W  = (SLOT_W + 1 > PC_W) ? SLOT_W + 1 : PC_W;
  localparam int CW     = (CPU_W + 1 > NC_W) ? CPU_W + 1 : NC_W;

  // configuration
  logic [PC_W-1:0] process_count;
  logic [NC_W-1:0] cpus_in_use;

  // control state
  seq_state_t state, state_next;
  logic [SLOT_W:0]   scan_idx;
  logic              chk_vld;
  logic [SLOT_W-1:0] chk_idx;
  logic [CPU_W:0]    ex_idx;
  logic              ex_vld;
  logic [CPU_W-1:0]  ex_cpu;
  logic              cpu_busy [NUM_CPUS];
  logic [SLOT_W-1:0] cpu_slot [NUM_CPUS];
  logic [MAX_PROCS-1:0] done_bits;
  logic [TIME_W-1:0] now_time;
  event_t            ev, ev_next;
  logic              ev_valid, ev_valid_next;

  // memory port
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  proc_entry_t       wr_data;
  logic [SLOT_W-1:0] rd_addr;
  proc_entry_t       rd;

  // datapath
  logic              idle_any;
  logic [CPU_W-1:0]  idle_cpu;
  logic              issue_scan, issue_ex;
  logic [CPU_W-1:0]  ex_sel;
  logic              elig, do_disp, do_ex, fin, load_hit;
  logic [WORK_W-1:0] rem_new;
  logic [TIME_W-1:0] comp, tat, wait_v, now_inc, now_fwd;
  logic              all_fin;

  mcfd_proc_mem #(.DEPTH(MAX_PROCS), .AW(SLOT_W)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // lowest idle CPU in use
  always_comb begin
    idle_any = 1'b0;
    idle_cpu = '0;
    for (int c = NUM_CPUS - 1; c >= 0; c--) begin
      if (!cpu_busy[c] && (CW'(c) < CW'(cpus_in_use))) begin
        idle_any = 1'b1;
        idle_cpu = CPU_W'(c);
      end
    end
  end

  // every slot in use finished
  always_comb begin
    all_fin = 1'b1;
    for (int i = 0; i < MAX_PROCS; i++) begin
      if ((CNT_W'(i) < CNT_W'(process_count)) && !done_bits[i]) begin
        all_fin = 1'b0;
      end
    end
  end

  // scan and CPU pass control
  always_comb begin
    issue_scan = (state == S_DISP) && idle_any &&
                 (scan_idx < (SLOT_W + 1)'(MAX_PROCS)) &&
                 (CNT_W'(scan_idx) < CNT_W'(process_count));
    issue_ex   = (state == S_EXEC) && (ex_idx < (CPU_W + 1)'(NUM_CPUS));
    ex_sel     = issue_ex ? ex_idx[CPU_W-1:0] : '0;
    rd_addr    = (state == S_DISP) ? scan_idx[SLOT_W-1:0] : cpu_slot[ex_sel];
  end

  // per-entry arithmetic
  always_comb begin
    elig     = (rd.status == ST_READY) && (rd.remaining != '0) &&
               (rd.arrival <= now_time);
    do_disp  = (state == S_DISP) && chk_vld && idle_any && elig;
    do_ex    = (state == S_EXEC) && ex_vld;
    rem_new  = (rd.remaining != '0) ? rd.remaining - 1'b1 : '0;
    fin      = (rem_new == '0);
    now_inc  = (now_time == TIME_MAX) ? TIME_MAX : now_time + 1'b1;
    comp     = now_inc;
    tat      = (comp >= rd.arrival) ? comp - rd.arrival : '0;
    wait_v   = (tat >= TIME_W'(rd.burst)) ? tat - TIME_W'(rd.burst) : '0;
    load_hit = (state == S_IDLE) && start && (op == OP_LOAD) &&
               (int'(slot) < MAX_PROCS);
    now_fwd  = now_inc;
  end

  // memory write selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd;
    if (load_hit) begin
      wr_en             = 1'b1;
      wr_addr           = SLOT_W'(slot);
      wr_data.ident     = process_id;
      wr_data.arrival   = arrival;
      wr_data.burst     = burst;
      wr_data.remaining = burst;
      wr_data.status    = ST_READY;
    end else if (do_disp) begin
      wr_en          = 1'b1;
      wr_addr        = chk_idx;
      wr_data.status = ST_RUNNING;
    end else if (do_ex) begin
      wr_en             = 1'b1;
      wr_addr           = cpu_slot[ex_cpu];
      wr_data.remaining = rem_new;
      if (fin) begin
        wr_data.status = ST_DONE;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && (op == OP_TICK)) begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (!idle_any || (!chk_vld && !issue_scan)) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!issue_ex && !ex_vld) begin
          state_next = S_END;
        end
      end
      S_END:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // result selection
  always_comb begin
    ev_next       = '0;
    ev_valid_next = 1'b0;
    case (state)
      S_DISP: begin
        if (do_disp) begin
          ev_valid_next = 1'b1;
          ev_next.kind  = EV_DISPATCH;
          ev_next.cpu   = 2'(idle_cpu);
          ev_next.pslot = 4'(chk_idx);
          ev_next.pid   = rd.ident;
          ev_next.etime = now_time;
          ev_next.resp  = now_time - rd.arrival;
        end
      end
      S_EXEC: begin
        if (do_ex && fin) begin
          ev_valid_next  = 1'b1;
          ev_next.kind   = EV_FINISH;
          ev_next.cpu    = 2'(ex_cpu);
          ev_next.pslot  = 4'(cpu_slot[ex_cpu]);
          ev_next.pid    = rd.ident;
          ev_next.etime  = comp;
          ev_next.tat    = tat;
          ev_next.wait_t = wait_v;
        end
      end
      S_END: begin
        ev_valid_next    = 1'b1;
        ev_next.kind     = EV_TICK_END;
        ev_next.etime    = now_fwd;
        ev_next.all_done = all_fin;
        ev_next.last     = 1'b1;
      end
      default: ev_valid_next = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      process_count <= PC_RESET;
      cpus_in_use   <= NC_RESET;
      chk_vld       <= 1'b0;
      ex_vld        <= 1'b0;
      done_bits     <= '0;
      now_time      <= '0;
      ev_valid      <= 1'b0;
      for (int c = 0; c < NUM_CPUS; c++) begin
        cpu_busy[c] <= 1'b0;
        cpu_slot[c] <= '0;
      end
    end else begin
      state    <= state_next;
      ev_valid <= ev_valid_next;

      // configuration writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PROCESS_COUNT: process_count <= cfg_data[PC_W-1:0];
          CFG_CPUS_IN_USE:   cpus_in_use   <= cfg_data[NC_W-1:0];
          default:           process_count <= process_count;
        endcase
      end

      // pipeline valid flags
      chk_vld <= issue_scan;
      ex_vld  <= issue_ex && cpu_busy[ex_sel] && (CW'(ex_idx) < CW'(cpus_in_use));

      // CPU ownership
      for (int c = 0; c < NUM_CPUS; c++) begin
        if (load_hit && cpu_busy[c] && (cpu_slot[c] == SLOT_W'(slot))) begin
          cpu_busy[c] <= 1'b0;
        end
        if (do_disp && (idle_cpu == CPU_W'(c))) begin
          cpu_busy[c] <= 1'b1;
          cpu_slot[c] <= chk_idx;
        end
        if (do_ex && fin && (ex_cpu == CPU_W'(c))) begin
          cpu_busy[c] <= 1'b0;
          cpu_slot[c] <= '0;
        end
      end

      // finished-slot flags
      if (load_hit) begin
        done_bits[SLOT_W'(slot)] <= 1'b0;
      end
      if (do_ex && fin) begin
        done_bits[cpu_slot[ex_cpu]] <= 1'b1;
      end

      if (state == S_END) begin
        now_time <= now_fwd;
      end
    end
  end

  // counters and result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      scan_idx <= '0;
      ex_idx   <= '0;
    end else begin
      if (issue_scan) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (issue_ex) begin
        ex_idx <= ex_idx + 1'b1;
      end
    end
    chk_idx <= scan_idx[SLOT_W-1:0];
    ex_cpu  <= ex_sel;
    ev      <= ev_next;
  end

  assign result_valid    = ev_valid;
  assign event_kind      = ev.kind;
  assign cpu_index       = ev.cpu;
  assign process_slot    = ev.pslot;
  assign pid_out         = ev.pid;
  assign event_time      = ev.etime;
  assign response_time   = ev.resp;
  assign turnaround_time = ev.tat;
  assign waiting_time    = ev.wait_t;
  assign all_done        = ev.all_done;
  assign last            = ev.last;

endmodule

// ----- sv/mcfd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfd_checker
// Port-level checks of the dispatcher's result stream and sequencing.
// ----------------------------------------------------------------------------
module mcfd_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       op,
  input logic       result_valid,
  input logic [1:0] event_kind,
  input logic       last
);
  import mcfd_pkg::*;

  // only the tick end closes a tick
  a_last_is_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> event_kind == EV_TICK_END)
    else $error("last on a result that is not a tick end");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && event_kind == EV_TICK_END |-> last)
    else $error("tick end without last");

  // a tick transaction starts a busy period
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && op == OP_TICK |=> busy)
    else $error("tick accepted but block not busy");

  // nothing follows the tick end directly
  a_gap_after_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |=> !result_valid)
    else $error("result directly after tick end");

  // reset leaves the block quiet
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid && !busy)
    else $error("activity right after reset");

endmodule

bind multi_cpu_fcfs_dispatcher mcfd_checker u_mcfd_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .op           (op),
  .result_valid (result_valid),
  .event_kind   (event_kind),
  .last         (last)
);

// ----- tb/tb_dispatch_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dispatch_checker
// Watches the job, register and event ports of the dispatcher. It keeps its
// own copy of the process table and CPU state, predicts the events of every
// tick, and compares each event field by field, oldest first.
// ----------------------------------------------------------------------------
module tb_dispatch_checker
  import mcfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  op,
  input  logic [3:0]            slot,
  input  logic [ID_W-1:0]       process_id,
  input  logic [TIME_W-1:0]     arrival,
  input  logic [WORK_W-1:0]     burst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  result_valid,
  input  logic [1:0]            event_kind,
  input  logic [1:0]            cpu_index,
  input  logic [3:0]            process_slot,
  input  logic [ID_W-1:0]       pid_out,
  input  logic [TIME_W-1:0]     event_time,
  input  logic [TIME_W-1:0]     response_time,
  input  logic [TIME_W-1:0]     turnaround_time,
  input  logic [TIME_W-1:0]     waiting_time,
  input  logic                  all_done,
  input  logic                  last,
  output int                    fail_count,
  output int                    pending_events
);

  localparam int NPROC = MAX_PROCS_DEF;
  localparam int NCPU  = NUM_CPUS_DEF;

  // Predicted process table and CPU state
  logic [TIME_W-1:0] tab_arr  [NPROC];
  logic [WORK_W-1:0] tab_burst[NPROC];
  logic [WORK_W-1:0] tab_left [NPROC];
  logic [ID_W-1:0]   tab_id   [NPROC];
  proc_status_t      tab_st   [NPROC];
  logic              cpu_on   [NCPU];
  logic [3:0]        cpu_proc [NCPU];
  logic [TIME_W-1:0] clock_now;
  logic [PC_W-1:0]   reg_pc;
  logic [NC_W-1:0]   reg_nc;

  event_t event_q[$];

  assign pending_events = event_q.size();

  function automatic event_t make_event(logic [1:0] k, int c, int s,
                                        logic [ID_W-1:0] id, logic [TIME_W-1:0] t,
                                        logic [TIME_W-1:0] rp, logic [TIME_W-1:0] ta,
                                        logic [TIME_W-1:0] wt, logic ad, logic lst);
    event_t e;
    e.kind = k; e.cpu = c[1:0]; e.pslot = s[3:0]; e.pid = id; e.etime = t;
    e.resp = rp; e.tat = ta; e.wait_t = wt; e.all_done = ad; e.last = lst;
    return e;
  endfunction

  // Apply a load: frees any CPU holding the slot
  task automatic load_slot(logic [3:0] s, logic [ID_W-1:0] id,
                           logic [TIME_W-1:0] a, logic [WORK_W-1:0] b);
    for (int c = 0; c < NCPU; c++)
      if (cpu_on[c] && cpu_proc[c] == s) cpu_on[c] = 1'b0;
    tab_id[s] = id; tab_arr[s] = a; tab_burst[s] = b; tab_left[s] = b;
    tab_st[s] = ST_READY;
  endtask

  // Dispatch, run one unit, advance time, tick end
  task automatic predict_tick();
    int pc, nc;
    logic all;
    logic [TIME_W-1:0] comp, tat, wt;
    pc = (reg_pc > NPROC) ? NPROC : reg_pc;
    nc = (reg_nc > NCPU) ? NCPU : reg_nc;
    for (int c = 0; c < nc; c++) begin
      if (cpu_on[c]) continue;
      for (int i = 0; i < pc; i++) begin
        if (tab_st[i] == ST_READY && tab_left[i] != 0 && tab_arr[i] <= clock_now) begin
          cpu_on[c] = 1'b1; cpu_proc[c] = i[3:0]; tab_st[i] = ST_RUNNING;
          event_q.push_back(make_event(EV_DISPATCH, c, i, tab_id[i], clock_now,
                                       clock_now - tab_arr[i], '0, '0, 1'b0, 1'b0));
          break;
        end
      end
    end
    for (int c = 0; c < nc; c++) begin
      int s;
      if (!cpu_on[c]) continue;
      s = cpu_proc[c];
      if (tab_left[s] != 0) tab_left[s]--;
      if (tab_left[s] != 0) continue;
      comp = (clock_now < TIME_MAX) ? clock_now + 1'b1 : TIME_MAX;
      tat  = (comp >= tab_arr[s]) ? comp - tab_arr[s] : '0;
      wt   = (tat >= tab_burst[s]) ? tat - tab_burst[s] : '0;
      tab_st[s] = ST_DONE; cpu_on[c] = 1'b0; cpu_proc[c] = '0;
      event_q.push_back(make_event(EV_FINISH, c, s, tab_id[s], comp, '0, tat, wt,
                                   1'b0, 1'b0));
    end
    if (clock_now < TIME_MAX) clock_now++;
    all = 1'b1;
    for (int i = 0; i < pc; i++)
      if (tab_st[i] != ST_DONE) all = 1'b0;
    event_q.push_back(make_event(EV_TICK_END, 0, 0, '0, clock_now, '0, '0, '0,
                                 all, 1'b1));
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    event_t e;
    if (rst) begin
      for (int c = 0; c < NCPU; c++) begin
        cpu_on[c] = 1'b0; cpu_proc[c] = '0;
      end
      for (int i = 0; i < NPROC; i++) tab_st[i] = ST_NEW;
      clock_now = '0; reg_pc = PC_RESET; reg_nc = NC_RESET;
      event_q.delete();
    end else begin
      // Compare the event shown this cycle
      if (result_valid) begin
        if (event_q.size() == 0) begin
          $error("unexpected event: kind %0d", event_kind);
          fail_count++;
        end else begin
          e = event_q.pop_front();
          check_field("event_kind", e.kind, event_kind);
          check_field("cpu_index", e.cpu, cpu_index);
          check_field("process_slot", e.pslot, process_slot);
          check_field("pid_out", e.pid, pid_out);
          check_field("event_time", e.etime, event_time);
          check_field("response_time", e.resp, response_time);
          check_field("turnaround_time", e.tat, turnaround_time);
          check_field("waiting_time", e.wait_t, waiting_time);
          check_field("all_done", e.all_done, all_done);
          check_field("last", e.last, last);
        end
      end
      // Register write transaction
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PROCESS_COUNT) reg_pc = cfg_data;
        else reg_nc = cfg_data[NC_W-1:0];
      end
      // Job transaction
      if (start && !busy) begin
        if (op == OP_LOAD) load_slot(slot, process_id, arrival, burst);
        else predict_tick();
      end
    end
  end

  initial fail_count = 0;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the multi-CPU dispatcher: directed loads and ticks over the
// register extremes, then random workloads in phases with varied pacing.
// ----------------------------------------------------------------------------
module tb;
  import mcfd_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic op = OP_LOAD;
  logic [3:0] slot = '0;
  logic [ID_W-1:0] process_id = '0;
  logic [TIME_W-1:0] arrival = '0;
  logic [WORK_W-1:0] burst = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PROCESS_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic result_valid;
  logic [1:0] event_kind, cpu_index;
  logic [3:0] process_slot;
  logic [ID_W-1:0] pid_out;
  logic [TIME_W-1:0] event_time, response_time, turnaround_time, waiting_time;
  logic all_done, last;
  int fail_count, pending_events;
  int gap_pct;
  int cur_pc;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multi_cpu_fcfs_dispatcher dut (.*);
  tb_dispatch_checker chk (.*);

  // One job transaction, with idle gaps drawn before it; start stays high
  // after acceptance until the next job, a gap or a drain takes the bus
  task automatic send_job(logic o, logic [3:0] s, logic [ID_W-1:0] id,
                          logic [TIME_W-1:0] a, logic [WORK_W-1:0] b);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1; op <= o; slot <= s; process_id <= id; arrival <= a; burst <= b;
    do @(posedge clk); while (busy);
  endtask

  task automatic tick();
    send_job(OP_TICK, 4'($urandom), ID_W'($urandom), TIME_W'($urandom),
             WORK_W'($urandom));
  endtask

  // Wait until every predicted event is out, plus the tail of a tick
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_events != 0 || busy);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    drain();
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_PROCESS_COUNT) cur_pc = int'(v);
  endtask

  // Fill every slot in use so no unloaded slot is ever read
  task automatic fill_slots(int n, int arr_hi, int burst_hi);
    for (int i = 0; i < n && i < 16; i++)
      send_job(OP_LOAD, 4'(i), ID_W'($urandom), TIME_W'($urandom_range(arr_hi)),
               WORK_W'($urandom_range(burst_hi)));
  endtask

  initial begin
    cur_pc = 16;
    gap_pct = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, zero burst, late arrival, reload cases
    fill_slots(16, 3, 2);
    send_job(OP_LOAD, 4'd15, 8'hFF, 16'hFFFF, 12'hFFF);
    send_job(OP_LOAD, 4'd14, 8'h00, 16'h0000, 12'h000);
    send_job(OP_LOAD, 4'd0, 8'hA5, 16'h0000, 12'h001);
    tick(); tick();
    send_job(OP_LOAD, 4'd1, 8'h5A, 16'h0000, 12'h003);
    tick(); tick(); tick();
    send_job(OP_LOAD, 4'd0, 8'h11, 16'h0000, 12'h002);
    tick(); tick();
    write_reg(CFG_CPUS_IN_USE, 5'd1);
    tick(); tick();
    write_reg(CFG_CPUS_IN_USE, 5'd7);
    write_reg(CFG_PROCESS_COUNT, 5'd31);
    tick(); tick();
    write_reg(CFG_PROCESS_COUNT, 5'd1);
    write_reg(CFG_CPUS_IN_USE, 5'd0);
    tick();
    write_reg(CFG_PROCESS_COUNT, 5'd0);
    tick();

    // Random phases over several register settings
    for (int ph = 0; ph < 12; ph++) begin
      int n_items;
      gap_pct = (ph < 4) ? 6 : (ph < 8) ? 49 : 0;
      write_reg(CFG_PROCESS_COUNT,
                CFG_DATA_W'((ph % 3 == 0) ? 16 : $urandom_range(1, 16)));
      write_reg(CFG_CPUS_IN_USE,
                CFG_DATA_W'((ph % 4 == 0) ? 4 : $urandom_range(1, 4)));
      fill_slots(cur_pc, 12, 6);
      n_items = 0;
      while (n_items < 17) begin
        if ($urandom_range(99) < 25)
          send_job(OP_LOAD, 4'($urandom_range(15)), ID_W'($urandom),
                   TIME_W'(($urandom_range(9) == 0) ? $urandom : $urandom_range(40)),
                   WORK_W'(($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 8)));
        else tick();
        n_items++;
      end
      if (ph == 5) drain();
    end

    // Late arrival: the only slot in use does not arrive during the run
    drain();
    write_reg(CFG_PROCESS_COUNT, 5'd1);
    send_job(OP_LOAD, 4'd0, 8'h3C, 16'hFFFF, 12'd2);
    gap_pct = 0;
    tick(); tick(); tick(); tick();

    drain();
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- multi_cpu_fcfs_dispatcher.f -----
sv/mcfd_pkg.sv
sv/mcfd_proc_mem.sv
sv/multi_cpu_fcfs_dispatcher.sv
sv/mcfd_checker.sv
tb/tb_dispatch_checker.sv
tb/tb.sv
